@@ src/shh_pkg.sv @@
// package: scheme codes, hash constants and the running state type
`default_nettype none
package shh_pkg;

  typedef enum logic [3:0] {
    ALG_RS   = 4'd0,
    ALG_JS   = 4'd1,
    ALG_PJW  = 4'd2,
    ALG_ELF  = 4'd3,
    ALG_BKDR = 4'd4,
    ALG_SDBM = 4'd5,
    ALG_DJB  = 4'd6,
    ALG_DEK  = 4'd7,
    ALG_AP   = 4'd8
  } alg_e;

  localparam logic [31:0] RS_STEP    = 32'd378551;
  localparam logic [31:0] RS_START   = 32'd63689;
  localparam logic [31:0] JS_SEED    = 32'd1315423911;
  localparam logic [31:0] TOP_NIBBLE = 32'hF000_0000;
  localparam logic [31:0] DJB_SEED   = 32'd5381;
  localparam logic [31:0] AP_SEED    = 32'hAAAA_AAAA;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] rs_mul;
    logic [31:0] count;
  } shh_state_t;

  // starting hash of a scheme, zero for all schemes without a seed
  function automatic logic [31:0] seed_for(alg_e alg);
    logic [31:0] s;
    begin
      case (alg)
        ALG_JS:  s = JS_SEED;
        ALG_DJB: s = DJB_SEED;
        ALG_AP:  s = AP_SEED;
        default: s = 32'd0;
      endcase
      return s;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/shh_if.sv @@
// channel interfaces: byte input and hash output
`default_nettype none
interface shh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface shh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

@@ src/shh_step.sv @@
// one-byte hash update for all nine schemes, plus the closing value
`default_nettype none
module shh_step (
  input  shh_pkg::alg_e       alg_i,
  input  shh_pkg::shh_state_t state_i,
  input  logic [7:0]          data_byte_i,
  output logic [31:0]         hash_next_o,
  output logic [31:0]         rs_mul_next_o,
  output logic [31:0]         count_next_o,
  output logic [31:0]         hash_final_o
);
  import shh_pkg::*;

  logic [31:0] h;
  logic [31:0] c;
  logic [31:0] rs_prod;
  logic [31:0] ap_prod;
  logic [31:0] pjw_sh;
  logic [31:0] dek_rot;
  logic [4:0]  dek_amt;
  logic [63:0] dek_dbl;

  assign h = state_i.hash;
  assign c = {24'd0, data_byte_i};

  // the two products of the RS and AP schemes, each a single multiply
  assign rs_prod       = h * state_i.rs_mul;
  assign ap_prod       = c * {3'd0, h[31:3]};
  assign rs_mul_next_o = (alg_i == ALG_RS || alg_i > ALG_AP) ?
                         state_i.rs_mul * RS_STEP : state_i.rs_mul;
  assign count_next_o  = state_i.count + 32'd1;

  assign pjw_sh = {h[27:0], 4'd0} + c;

  always_comb begin
    case (alg_i)
      ALG_JS:   hash_next_o = h ^ ({h[26:0], 5'd0} + c + {2'd0, h[31:2]});
      ALG_PJW, ALG_ELF: begin
        if ((pjw_sh & TOP_NIBBLE) != 32'd0) begin
          hash_next_o = (pjw_sh ^ {24'd0, pjw_sh[31:28], 4'd0}) & ~TOP_NIBBLE;
        end else begin
          hash_next_o = pjw_sh;
        end
      end
      ALG_BKDR: hash_next_o = {h[24:0], 7'd0} + {h[30:0], 1'b0} + h + c;
      ALG_SDBM: hash_next_o = c + {h[25:0], 6'd0} + {h[15:0], 16'd0} - h;
      ALG_DJB:  hash_next_o = {h[26:0], 5'd0} + h + c;
      ALG_DEK:  hash_next_o = {h[26:0], h[31:27]} ^ c;
      ALG_AP: begin
        if (!state_i.count[0]) begin
          hash_next_o = h ^ ({h[24:0], 7'd0} ^ ap_prod);
        end else begin
          hash_next_o = h ^ ~({h[20:0], 11'd0} + (c ^ {5'd0, h[31:5]}));
        end
      end
      default:  hash_next_o = rs_prod + c;
    endcase
  end

  // length seed of DEK: rotl(count, 5 * count mod 32), count after this byte
  assign dek_amt = {count_next_o[2:0], 2'd0} + count_next_o[4:0];
  assign dek_dbl = {count_next_o, count_next_o} << dek_amt;
  assign dek_rot = dek_dbl[63:32];

  assign hash_final_o = (alg_i == ALG_DEK) ? (hash_next_o ^ dek_rot) : hash_next_o;

endmodule
`default_nettype wire

@@ src/selectable_string_hash_unit.sv @@
// top level: selectable 32-bit string hash over a byte stream
`default_nettype none
// Hashes a string delivered one byte per transfer and returns the 32-bit hash
// in one output transfer when the byte marked last has been taken. The
// algorithm register picks RS, JS, PJW, ELF, BKDR, SDBM, DJB, DEK or AP
// (codes 0..8, codes 9..15 run RS); writing it restarts the current string
// and must only happen while the block is idle. A byte transfer is taken
// each cycle unless intake is stalled: one input register feeds a single
// combinational update of the running hash, RS multiplier and byte count,
// and the closing hash lands in an output register. The last byte passes
// through the input register, and once the output slot is free the closing
// hash is written to the output register. Intake slows only when a finished
// hash still waits at the output while the next string's last byte is due.
module selectable_string_hash_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  shh_in_if.sink           in_i,
  shh_out_if.source        out_o
);
  import shh_pkg::*;

  // configuration and running state
  alg_e       alg_q;
  shh_state_t state_q, state_d;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q;

  logic        in_fire;
  logic        s1_adv;
  logic        s1_close;
  logic [31:0] hash_next;
  logic [31:0] rs_mul_next;
  logic [31:0] count_next;
  logic [31:0] hash_final;

  // a non-last byte always moves on; a last byte needs a free output slot
  assign s1_adv   = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign s1_close = s1_adv && s1_last_q;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  shh_step u_step (
    .alg_i         (alg_q),
    .state_i       (state_q),
    .data_byte_i   (s1_byte_q),
    .hash_next_o   (hash_next),
    .rs_mul_next_o (rs_mul_next),
    .count_next_o  (count_next),
    .hash_final_o  (hash_final)
  );

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      // new scheme: reseed and restart
      state_d.hash   = seed_for(alg_e'(cfg_wdata_i));
      state_d.rs_mul = RS_START;
      state_d.count  = 32'd0;
    end else if (s1_close) begin
      // string done: reseed for the next one
      state_d.hash   = seed_for(alg_q);
      state_d.rs_mul = RS_START;
      state_d.count  = 32'd0;
    end else if (s1_adv) begin
      state_d.hash   = hash_next;
      state_d.rs_mul = rs_mul_next;
      state_d.count  = count_next;
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (s1_close) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q          <= ALG_RS;
      state_q.hash   <= 32'd0;
      state_q.rs_mul <= RS_START;
      state_q.count  <= 32'd0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alg_q <= alg_e'(cfg_wdata_i);
      end
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (s1_close) begin
      out_hash_q <= hash_final;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

endmodule
`default_nettype wire
